// ===== design/rchsc_pkg.sv =====
package rchsc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_START_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_START_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_END_X   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_END_Y   = 2'd3;

  localparam logic OP_SEGMENT = 1'b0;
  localparam logic OP_CIRCLE  = 1'b1;

  localparam longint unsigned HitRange = 64'd10000000;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        collider_id;
    logic signed [31:0] p_x;
    logic signed [31:0] p_y;
    logic signed [31:0] q_x;
    logic signed [31:0] q_y;
    logic [30:0]        radius;
    logic               last;
  } item_t;

  typedef struct packed {
    logic               hit_found;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic [15:0]        hit_collider;
  } hit_t;

  // sign and magnitude of a value clamped to +-(2^31-1)
  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } sm_t;

  function automatic logic signed [31:0] clamp_diff(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -33'sd2147483647) r = 32'sh8000_0001;
    else r = signed'(v[31:0]);
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_out(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -34'sd2147483648) r = 32'sh8000_0000;
    else r = signed'(v[31:0]);
    return r;
  endfunction

  // truncate toward zero by 2^30, then clamp
  function automatic sm_t scale30(input logic signed [67:0] v);
    logic [67:0] m;
    logic [67:0] s;
    sm_t         r;
    m = v[67] ? 68'(-v) : 68'(v);
    s = m >> 30;
    r.neg = v[67];
    r.mag = (s > 68'd2147483647) ? 31'h7FFF_FFFF : s[30:0];
    return r;
  endfunction

endpackage

// ===== design/ray_closest_hit_segments_circles.sv =====
// A circle transaction runs two 32-step square roots and two 31-step divisions, a segment
// transaction one division; early misses finish sooner.
// One item at a time: the next is accepted only once the block is back in idle after the
// current one finishes; a stalled result holds the final step.
// Every product goes through the shared 34x34 multiplier; divide and square root are bit-serial.
// Synchronous active-high reset clears the ray, nearest-hit state and valid.
module ray_closest_hit_segments_circles #(
  parameter int FRAC_BITS = 16,
  parameter int ID_WIDTH  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  rchsc_pkg::item_t                   item,
  output logic                               hit_valid,
  input  logic                               hit_stall,
  output rchsc_pkg::hit_t                    hit,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rchsc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam logic [63:0] RangeLim = 64'(rchsc_pkg::HitRange) << FRAC_BITS;
  localparam logic [63:0] RangeSq  =
    (RangeLim >= 64'h1_0000_0000) ? 64'hFFFF_FFFF_FFFF_FFFF : RangeLim * RangeLim;
  localparam logic [15:0] IdMask =
    (ID_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << ID_WIDTH) - 32'd1);

  localparam logic [5:0] S_IDLE = 6'd0,  S_DIFF = 6'd1,
    S_SM0 = 6'd2,  S_SM1 = 6'd3,  S_SM2 = 6'd4,  S_SM3 = 6'd5,  S_SM4 = 6'd6,
    S_SM5 = 6'd7,  S_SM6 = 6'd8,  S_SNEG = 6'd9, S_SCHK = 6'd10,
    S_SOFF0 = 6'd11, S_SOFF1 = 6'd12, S_SOFF2 = 6'd13,
    S_CM0 = 6'd14, S_CM1 = 6'd15, S_CM2 = 6'd16, S_CM3 = 6'd17, S_CM4 = 6'd18,
    S_CM5 = 6'd19, S_CDX = 6'd20, S_CDY = 6'd21,
    S_CA0 = 6'd22, S_CA1 = 6'd23, S_CA2 = 6'd24, S_CA3 = 6'd25, S_CA4 = 6'd26,
    S_CA5 = 6'd27, S_CA6 = 6'd28, S_CA7 = 6'd29,
    S_CT0 = 6'd30, S_CT1 = 6'd31, S_CT2 = 6'd32, S_CT3 = 6'd33, S_CT4 = 6'd34,
    S_CT5 = 6'd35, S_CT6 = 6'd36,
    S_DS0 = 6'd37, S_DS1 = 6'd38, S_DS2 = 6'd39, S_DS3 = 6'd40, S_DS4 = 6'd41,
    S_FIN = 6'd42, S_DIV = 6'd43, S_SQRT = 6'd44;

  logic [5:0]         state, ret;
  logic [5:0]         cnt;
  rchsc_pkg::item_t   cur;

  logic signed [31:0] start_x, start_y, end_x, end_y;
  logic [63:0]        best_dist;
  logic signed [31:0] best_x, best_y;
  logic [15:0]        best_owner;
  logic               any_hit;

  logic signed [31:0] d_x, d_y, r_x, r_y, w_x, w_y;
  logic               r_xn, r_yn;
  logic signed [65:0] acc_d, acc_u, acc_t;
  logic [63:0]        len2, oc2, r2;
  logic signed [31:0] u_x, u_y, a_r;
  logic               a_n;
  logic [30:0]        a_m;
  logic               orig_in;
  logic signed [33:0] t_r;
  logic               ox_n, oy_n;
  logic [30:0]        ox_m, oy_m;
  logic signed [31:0] hx, hy, ex, ey;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;

  logic [64:0]        rem;
  logic [63:0]        den;
  logic [32:0]        quo;
  logic               div_ge;
  logic [64:0]        div_r1;

  logic [63:0]        sv, sres, sbit, sq_rb;
  logic               sq_ge;

  rchsc_pkg::sm_t     sc_acc, sc_prod;
  logic [30:0]        seg_off;
  logic [31:0]        dx_abs, dy_abs;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  assign div_ge  = (rem >= {1'b0, den});
  assign div_r1  = div_ge ? rem - {1'b0, den} : rem;
  assign sq_rb   = sres | sbit;
  assign sq_ge   = (sv >= sq_rb);
  assign sc_acc  = rchsc_pkg::scale30(68'(acc_d));
  assign sc_prod = rchsc_pkg::scale30(prod);
  assign seg_off = prod[62:32];
  assign dx_abs  = d_x[31] ? 32'(-d_x) : 32'(d_x);
  assign dy_abs  = d_y[31] ? 32'(-d_y) : 32'(d_y);

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SM0:   begin ma = 34'(r_x);  mb = 34'(d_y); end
      S_SM1:   begin ma = 34'(r_y);  mb = 34'(d_x); end
      S_SM2:   begin ma = 34'(w_x);  mb = 34'(r_y); end
      S_SM3:   begin ma = 34'(w_y);  mb = 34'(r_x); end
      S_SM4:   begin ma = 34'(w_x);  mb = 34'(d_y); end
      S_SM5:   begin ma = 34'(w_y);  mb = 34'(d_x); end
      S_SOFF0: begin ma = 34'(r_x);  mb = 34'(quo); end
      S_SOFF1: begin ma = 34'(r_y);  mb = 34'(quo); end
      S_CM0:   begin ma = 34'(d_x);  mb = 34'(d_x); end
      S_CM1:   begin ma = 34'(d_y);  mb = 34'(d_y); end
      S_CM2:   begin ma = 34'(w_x);  mb = 34'(w_x); end
      S_CM3:   begin ma = 34'(w_y);  mb = 34'(w_y); end
      S_CM4:   begin ma = 34'(cur.radius); mb = 34'(cur.radius); end
      S_CA0:   begin ma = 34'(w_x);  mb = 34'(u_x); end
      S_CA1:   begin ma = 34'(w_y);  mb = 34'(u_y); end
      S_CA4:   begin ma = 34'(sc_acc.mag); mb = 34'(sc_acc.mag); end
      S_CT1:   begin ma = 34'(u_x);  mb = t_r; end
      S_CT2:   begin ma = 34'(u_y);  mb = t_r; end
      S_CT3:   begin ma = 34'(sc_prod.mag); mb = 34'(sc_prod.mag); end
      S_CT4:   begin ma = 34'(ox_m); mb = 34'(ox_m); end
      S_DS1:   begin ma = 34'(ex);   mb = 34'(ex); end
      S_DS2:   begin ma = 34'(ey);   mb = 34'(ey); end
      default: begin ma = '0;        mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      cnt        <= '0;
      hit_valid  <= 1'b0;
      start_x    <= '0;
      start_y    <= '0;
      end_x      <= '0;
      end_y      <= '0;
      best_dist  <= '1;
      best_x     <= '0;
      best_y     <= '0;
      best_owner <= '0;
      any_hit    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rchsc_pkg::REG_START_X: start_x <= signed'(cfg_data);
          rchsc_pkg::REG_START_Y: start_y <= signed'(cfg_data);
          rchsc_pkg::REG_END_X:   end_x   <= signed'(cfg_data);
          rchsc_pkg::REG_END_Y:   end_y   <= signed'(cfg_data);
          default: ;
        endcase
      end

      if (hit_valid && !hit_stall && !(state == S_FIN && cur.last)) hit_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur   <= item;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          d_x <= rchsc_pkg::clamp_diff(33'(end_x) - 33'(start_x));
          d_y <= rchsc_pkg::clamp_diff(33'(end_y) - 33'(start_y));
          r_x <= rchsc_pkg::clamp_diff(33'(cur.q_x) - 33'(cur.p_x));
          r_y <= rchsc_pkg::clamp_diff(33'(cur.q_y) - 33'(cur.p_y));
          if (cur.opcode == rchsc_pkg::OP_SEGMENT) begin
            w_x   <= rchsc_pkg::clamp_diff(33'(start_x) - 33'(cur.p_x));
            w_y   <= rchsc_pkg::clamp_diff(33'(start_y) - 33'(cur.p_y));
            state <= S_SM0;
          end else begin
            w_x   <= rchsc_pkg::clamp_diff(33'(cur.p_x) - 33'(start_x));
            w_y   <= rchsc_pkg::clamp_diff(33'(cur.p_y) - 33'(start_y));
            state <= S_CM0;
          end
        end
        S_SM0: state <= S_SM1;
        S_SM1: begin acc_d <= 66'(prod);         state <= S_SM2; end
        S_SM2: begin acc_d <= acc_d - 66'(prod); state <= S_SM3; end
        S_SM3: begin acc_u <= 66'(prod);         state <= S_SM4; end
        S_SM4: begin acc_u <= acc_u - 66'(prod); state <= S_SM5; end
        S_SM5: begin acc_t <= 66'(prod);         state <= S_SM6; end
        S_SM6: begin acc_t <= acc_t - 66'(prod); state <= S_SNEG; end
        S_SNEG: begin
          r_xn <= r_x[31];
          r_yn <= r_y[31];
          r_x  <= r_x[31] ? -r_x : r_x;
          r_y  <= r_y[31] ? -r_y : r_y;
          if (acc_d[65]) begin
            acc_d <= -acc_d;
            acc_u <= -acc_u;
            acc_t <= -acc_t;
          end
          state <= (acc_d == '0) ? S_FIN : S_SCHK;
        end
        S_SCHK: begin
          if (acc_u[65] || acc_u > acc_d || acc_t[65] || acc_t > acc_d) begin
            state <= S_FIN;
          end else begin
            rem   <= {1'b0, acc_t[63:0]};
            den   <= acc_d[63:0];
            quo   <= '0;
            cnt   <= 6'd32;
            ret   <= S_SOFF0;
            state <= S_DIV;
          end
        end
        S_SOFF0: state <= S_SOFF1;
        S_SOFF1: begin
          hx <= rchsc_pkg::clamp_out(r_xn ? 34'(cur.p_x) - 34'(seg_off)
                                          : 34'(cur.p_x) + 34'(seg_off));
          state <= S_SOFF2;
        end
        S_SOFF2: begin
          hy <= rchsc_pkg::clamp_out(r_yn ? 34'(cur.p_y) - 34'(seg_off)
                                          : 34'(cur.p_y) + 34'(seg_off));
          state <= S_DS0;
        end
        S_CM0: state <= S_CM1;
        S_CM1: begin len2 <= prod[63:0];        state <= S_CM2; end
        S_CM2: begin len2 <= len2 + prod[63:0]; state <= S_CM3; end
        S_CM3: begin oc2  <= prod[63:0];        state <= S_CM4; end
        S_CM4: begin oc2  <= oc2 + prod[63:0];  state <= S_CM5; end
        S_CM5: begin
          r2 <= prod[63:0];
          if (len2 == '0) begin
            state <= S_FIN;
          end else begin
            sv    <= len2;
            sres  <= '0;
            sbit  <= 64'h4000_0000_0000_0000;
            cnt   <= 6'd31;
            ret   <= S_CDX;
            state <= S_SQRT;
          end
        end
        S_CDX: begin
          rem   <= 65'(dx_abs);
          den   <= sres;
          quo   <= '0;
          cnt   <= 6'd30;
          ret   <= S_CDY;
          state <= S_DIV;
        end
        S_CDY: begin
          u_x   <= d_x[31] ? -signed'(32'(quo[30:0])) : signed'(32'(quo[30:0]));
          rem   <= 65'(dy_abs);
          quo   <= '0;
          cnt   <= 6'd30;
          ret   <= S_CA0;
          state <= S_DIV;
        end
        S_CA0: begin
          u_y   <= d_y[31] ? -signed'(32'(quo[30:0])) : signed'(32'(quo[30:0]));
          state <= S_CA1;
        end
        S_CA1: begin acc_d <= 66'(prod);         state <= S_CA2; end
        S_CA2: begin acc_d <= acc_d + 66'(prod); state <= S_CA3; end
        S_CA3: begin
          a_n   <= sc_acc.neg;
          a_m   <= sc_acc.mag;
          state <= S_CA4;
        end
        S_CA4: begin
          a_r   <= a_n ? -signed'(32'(a_m)) : signed'(32'(a_m));
          state <= S_CA5;
        end
        S_CA5: begin acc_d <= 66'(r2) + 66'(prod); state <= S_CA6; end
        S_CA6: begin
          acc_d   <= acc_d - 66'(oc2);
          orig_in <= (oc2 < r2);
          state   <= S_CA7;
        end
        S_CA7: begin
          if (acc_d[65]) begin
            state <= S_FIN;
          end else begin
            sv    <= acc_d[63:0];
            sres  <= '0;
            sbit  <= 64'h4000_0000_0000_0000;
            cnt   <= 6'd31;
            ret   <= S_CT0;
            state <= S_SQRT;
          end
        end
        S_CT0: begin
          t_r   <= orig_in ? 34'(a_r) + 34'(sres[31:0]) : 34'(a_r) - 34'(sres[31:0]);
          state <= S_CT1;
        end
        S_CT1: state <= t_r[33] ? S_FIN : S_CT2;
        S_CT2: begin
          ox_n  <= sc_prod.neg;
          ox_m  <= sc_prod.mag;
          state <= S_CT3;
        end
        S_CT3: begin
          oy_n  <= sc_prod.neg;
          oy_m  <= sc_prod.mag;
          state <= S_CT4;
        end
        S_CT4: begin acc_d <= 66'(prod);         state <= S_CT5; end
        S_CT5: begin acc_d <= acc_d + 66'(prod); state <= S_CT6; end
        S_CT6: begin
          hx <= rchsc_pkg::clamp_out(ox_n ? 34'(start_x) - 34'(ox_m)
                                          : 34'(start_x) + 34'(ox_m));
          hy <= rchsc_pkg::clamp_out(oy_n ? 34'(start_y) - 34'(oy_m)
                                          : 34'(start_y) + 34'(oy_m));
          state <= (acc_d[63:0] < len2) ? S_DS0 : S_FIN;
        end
        S_DS0: begin
          ex    <= rchsc_pkg::clamp_diff(33'(hx) - 33'(start_x));
          ey    <= rchsc_pkg::clamp_diff(33'(hy) - 33'(start_y));
          state <= S_DS1;
        end
        S_DS1: state <= S_DS2;
        S_DS2: begin acc_d <= 66'(prod);         state <= S_DS3; end
        S_DS3: begin acc_d <= acc_d + 66'(prod); state <= S_DS4; end
        S_DS4: begin
          if (acc_d[63:0] <= RangeSq && acc_d[63:0] <= best_dist) begin
            best_dist  <= acc_d[63:0];
            best_x     <= hx;
            best_y     <= hy;
            best_owner <= cur.collider_id & IdMask;
            any_hit    <= 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (!hit_valid || !hit_stall) begin
            hit.hit_found    <= any_hit;
            hit.hit_x        <= any_hit ? best_x : '0;
            hit.hit_y        <= any_hit ? best_y : '0;
            hit.hit_collider <= any_hit ? best_owner : '0;
            hit_valid        <= 1'b1;
            best_dist        <= '1;
            best_x           <= '0;
            best_y           <= '0;
            best_owner       <= '0;
            any_hit          <= 1'b0;
            state            <= S_IDLE;
          end
        end
        S_DIV: begin
          rem <= {div_r1[63:0], 1'b0};
          quo <= {quo[31:0], div_ge};
          cnt <= cnt - 6'd1;
          if (cnt == '0) state <= ret;
        end
        S_SQRT: begin
          if (sq_ge) begin
            sv   <= sv - sq_rb;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= cnt - 6'd1;
          if (cnt == '0) state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rose_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(hit_valid) |-> $past(state) == S_FIN && $past(cur.last))
    else $error("result raised outside a last transaction");

  a_best_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(hit_valid) |-> !any_hit && best_dist == '1)
    else $error("nearest-hit state not cleared after result");

  a_sqrt_width: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT && cnt == '0 |=> sres[63:32] == '0)
    else $error("square root wider than 32 bits");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem <= {den, 1'b0})
    else $error("divider remainder out of range");
`endif

endmodule

// ===== test/tb_ray_closest_hit_segments_circles.sv =====
module tb_ray_closest_hit_segments_circles;

  localparam longint DMAX = 64'sd2147483647;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  rchsc_pkg::item_t item = '0;
  logic hit_valid;
  logic hit_stall = 1'b0;
  rchsc_pkg::hit_t hit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rchsc_pkg::CfgIdxW-1:0] cfg_index = rchsc_pkg::REG_START_X;
  logic [31:0] cfg_data = '0;

  ray_closest_hit_segments_circles u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .hit_valid(hit_valid), .hit_stall(hit_stall), .hit(hit),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  longint ray_sx, ray_sy, ray_ex, ray_ey;
  longint unsigned near_dist;
  longint near_x, near_y;
  logic [15:0] near_id;
  bit near_any;

  rchsc_pkg::item_t pending_items[$];
  rchsc_pkg::hit_t expected_hits[$];
  int mismatches = 0;
  bit calm = 1'b0;

  function automatic longint clampd(longint x);
    if (x > DMAX) return DMAX;
    if (x < -DMAX) return -DMAX;
    return x;
  endfunction

  function automatic longint clampo(longint x);
    if (x > DMAX) return DMAX;
    if (x < -DMAX - 1) return -DMAX - 1;
    return x;
  endfunction

  function automatic longint unsigned absval(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint trunc_shift(longint x, int n);
    return signed_of(absval(x) >> n, x < 0);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit segment_hit(longint px, longint py, longint qx, longint qy,
                                     output longint hx, output longint hy);
    longint rx, ry, dx, dy, wx, wy, d, nu, nt;
    longint unsigned ud, rem, frac, t;
    rx = clampd(qx - px); ry = clampd(qy - py);
    dx = clampd(ray_ex - ray_sx); dy = clampd(ray_ey - ray_sy);
    wx = clampd(ray_sx - px); wy = clampd(ray_sy - py);
    d = rx * dy - ry * dx;
    nu = wx * ry - wy * rx;
    nt = wx * dy - wy * dx;
    hx = 0; hy = 0;
    if (d == 0) return 0;
    if (d < 0) begin d = -d; nu = -nu; nt = -nt; end
    if (nu < 0 || nu > d || nt < 0 || nt > d) return 0;
    ud = d; rem = nt; t = 0; frac = 0;
    if (rem >= ud) begin rem -= ud; t = 64'd1 << 32; end
    for (int i = 0; i < 32; i++) begin
      rem <<= 1;
      frac <<= 1;
      if (rem >= ud) begin rem -= ud; frac |= 1; end
    end
    t |= frac;
    hx = clampo(px + signed_of(longint'((absval(rx) * t) >> 32), rx < 0));
    hy = clampo(py + signed_of(longint'((absval(ry) * t) >> 32), ry < 0));
    return 1;
  endfunction

  function automatic bit circle_hit(longint cx, longint cy, longint unsigned rad,
                                    output longint hx, output longint hy);
    longint dx, dy, ux, uy, ocx, ocy, a, disc, f, t, ox, oy;
    longint unsigned len2, len, oc2, r2, a2, off2;
    hx = 0; hy = 0;
    dx = clampd(ray_ex - ray_sx); dy = clampd(ray_ey - ray_sy);
    len2 = longint'(dx * dx) + longint'(dy * dy);
    if (len2 == 0) return 0;
    len = floor_sqrt(len2);
    ux = signed_of((absval(dx) << 30) / len, dx < 0);
    uy = signed_of((absval(dy) << 30) / len, dy < 0);
    ocx = clampd(cx - ray_sx); ocy = clampd(cy - ray_sy);
    a = clampd(trunc_shift(ocx * ux + ocy * uy, 30));
    a2 = a * a;
    oc2 = longint'(ocx * ocx) + longint'(ocy * ocy);
    r2 = rad * rad;
    disc = longint'(r2 + a2) - longint'(oc2);
    if (disc < 0) return 0;
    f = floor_sqrt(disc);
    t = (oc2 < r2) ? a + f : a - f;
    if (t < 0) return 0;
    ox = clampd(trunc_shift(ux * t, 30));
    oy = clampd(trunc_shift(uy * t, 30));
    off2 = longint'(ox * ox) + longint'(oy * oy);
    if (!(off2 < len2)) return 0;
    hx = clampo(ray_sx + ox);
    hy = clampo(ray_sy + oy);
    return 1;
  endfunction

  function automatic void clear_nearest();
    near_dist = '1; near_x = 0; near_y = 0; near_id = 0; near_any = 0;
  endfunction

  function automatic void set_ray(logic [rchsc_pkg::CfgIdxW-1:0] idx, logic [31:0] v);
    case (idx)
      rchsc_pkg::REG_START_X: ray_sx = longint'(signed'(v));
      rchsc_pkg::REG_START_Y: ray_sy = longint'(signed'(v));
      rchsc_pkg::REG_END_X: ray_ex = longint'(signed'(v));
      rchsc_pkg::REG_END_Y: ray_ey = longint'(signed'(v));
      default: ;
    endcase
  endfunction

  function automatic void predict_hit(rchsc_pkg::item_t it);
    longint hx, hy, ex, ey;
    longint unsigned dsq, lim;
    bit h;
    rchsc_pkg::hit_t r;
    if (it.opcode == rchsc_pkg::OP_SEGMENT)
      h = segment_hit(longint'(it.p_x), longint'(it.p_y), longint'(it.q_x),
                      longint'(it.q_y), hx, hy);
    else
      h = circle_hit(longint'(it.p_x), longint'(it.p_y), {33'd0, it.radius}, hx, hy);
    if (h) begin
      ex = clampd(hx - ray_sx); ey = clampd(hy - ray_sy);
      dsq = longint'(ex * ex) + longint'(ey * ey);
      lim = rchsc_pkg::HitRange << 16;
      lim = (lim >= 64'h1_0000_0000) ? '1 : lim * lim;
      if (dsq <= lim && dsq <= near_dist) begin
        near_dist = dsq; near_x = hx; near_y = hy; near_id = it.collider_id; near_any = 1;
      end
    end
    if (it.last) begin
      r.hit_found = near_any;
      r.hit_x = near_any ? near_x[31:0] : '0;
      r.hit_y = near_any ? near_y[31:0] : '0;
      r.hit_collider = near_any ? near_id : '0;
      expected_hits = {expected_hits, r};
      clear_nearest();
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) predict_hit(item);
      if (!item_valid || !item_stall) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
          item_valid <= 1'b1;
          item <= pending_items.pop_front();
        end else item_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (hit_valid && !hit_stall) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected hit transaction %p", hit);
        end else begin
          rchsc_pkg::hit_t e;
          e = expected_hits.pop_front();
          if (hit !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("hit mismatch: expected %p got %p", e, hit);
          end
        end
      end
      hit_stall <= calm ? 1'b0 : ($urandom_range(99) < 27);
    end
  end

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF - $urandom_range(3);
      2: return 32'sh8000_0000 + $urandom_range(3);
      default: return signed'(32'($urandom_range(40 << 16))) - (20 << 16);
    endcase
  endfunction

  function automatic rchsc_pkg::item_t rnd_item(bit lst);
    rchsc_pkg::item_t it;
    it.opcode = 1'($urandom_range(1));
    it.collider_id = 16'($urandom);
    it.p_x = rnd_coord(); it.p_y = rnd_coord();
    it.q_x = rnd_coord(); it.q_y = rnd_coord();
    if ($urandom_range(3) == 0) it.radius = 31'($urandom);
    else it.radius = 31'($urandom_range(12 << 16));
    it.last = lst;
    return it;
  endfunction

  function automatic rchsc_pkg::item_t mk(logic op, int id, int px, int py, int qx, int qy,
                                          int rad, logic lst);
    rchsc_pkg::item_t it;
    it.opcode = op; it.collider_id = 16'(id);
    it.p_x = px; it.p_y = py; it.q_x = qx; it.q_y = qy;
    it.radius = 31'(rad); it.last = lst;
    return it;
  endfunction

  task automatic enqueue(rchsc_pkg::item_t it);
    pending_items = {pending_items, it};
  endtask

  task automatic write_reg(logic [rchsc_pkg::CfgIdxW-1:0] idx, logic [31:0] v);
    cfg_index <= idx; cfg_data <= v; cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    set_ray(idx, v);
  endtask

  task automatic set_ray_all(int sx, int sy, int ex, int ey);
    write_reg(rchsc_pkg::REG_START_X, sx); write_reg(rchsc_pkg::REG_START_Y, sy);
    write_reg(rchsc_pkg::REG_END_X, ex); write_reg(rchsc_pkg::REG_END_Y, ey);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_hits.size() != 0);
    repeat (400) @(posedge clk);
  endtask

  localparam int U = 1 << 16;

  initial begin
    ray_sx = 0; ray_sy = 0; ray_ex = 0; ray_ey = 0;
    clear_nearest();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // zero-length ray: segment crossing origin, circle around origin
    enqueue(mk(rchsc_pkg::OP_SEGMENT, 1, -U, -U, U, U, 0, 1'b0));
    enqueue(mk(rchsc_pkg::OP_CIRCLE, 2, 0, 0, 0, 0, 5 * U, 1'b1));
    drain();
    set_ray_all(0, 0, 10 * U, 0);
    enqueue(mk(rchsc_pkg::OP_SEGMENT, 3, 5 * U, -U, 5 * U, U, 0, 1'b0));
    enqueue(mk(rchsc_pkg::OP_SEGMENT, 65535, 5 * U, -U, 5 * U, U, 123, 1'b0));
    enqueue(mk(rchsc_pkg::OP_SEGMENT, 4, 2 * U, -U, 2 * U, 0, 0, 1'b1));
    enqueue(mk(rchsc_pkg::OP_SEGMENT, 5, 0, U, 9 * U, U, 0, 1'b1));
    enqueue(mk(rchsc_pkg::OP_SEGMENT, 6, 3 * U, U, 3 * U, 2 * U, 0, 1'b1));
    enqueue(mk(rchsc_pkg::OP_CIRCLE, 7, 6 * U, 0, 99, 99, 2 * U, 1'b0));
    enqueue(mk(rchsc_pkg::OP_CIRCLE, 8, 0, 0, 0, 0, 3 * U, 1'b1));
    enqueue(mk(rchsc_pkg::OP_CIRCLE, 9, -6 * U, 0, 0, 0, 2 * U, 1'b1));
    enqueue(mk(rchsc_pkg::OP_CIRCLE, 10, 20 * U, 0, 0, 0, 2 * U, 1'b1));
    enqueue(mk(rchsc_pkg::OP_CIRCLE, 11, 12 * U, 0, 0, 0, 2 * U, 1'b1));
    enqueue(mk(rchsc_pkg::OP_CIRCLE, 12, 5 * U, 0, 0, 0, 32'h7FFF_FFFF, 1'b1));
    drain();
    set_ray_all(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    enqueue(mk(rchsc_pkg::OP_CIRCLE, 13, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0,
               32'h7FFF_FFFF, 1'b0));
    enqueue(mk(rchsc_pkg::OP_SEGMENT, 14, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 0, 1'b1));
    enqueue(mk(rchsc_pkg::OP_CIRCLE, 15, 0, 0, 0, 0, 100 * U, 1'b1));
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) set_ray_all($urandom, $urandom, $urandom, $urandom);
      else set_ray_all(rnd_coord() >>> 2, rnd_coord() >>> 2,
                       (rnd_coord() >>> 1) + (ph * U), rnd_coord() >>> 1);
      calm = (ph == 3);
      for (int n = 0; n < 100; n++)
        enqueue(rnd_item($urandom_range(3) == 0 || n == 99));
      drain();
    end
    calm = 1'b0;
    if (mismatches == 0 && expected_hits.size() == 0)
      $display("tb_ray_closest_hit_segments_circles OK");
    else
      $display("tb_ray_closest_hit_segments_circles NOT OK");
    $finish;
  end

  initial begin
    #30000000;
    $display("tb_ray_closest_hit_segments_circles NOT OK");
    $finish;
  end

endmodule
